// ===== rtl/wrl_pkg.sv =====
// Shared types, sizes and helper functions for the windowed event rate limiter.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package wrl_pkg;

    // Sizing of the limiter.
    localparam int NUM_SOURCES = 16;
    localparam int MAX_STAMPS  = 64;
    localparam int TIME_BITS   = 32;

    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SLOT_W = $clog2(MAX_STAMPS);
    localparam int CNT_W  = $clog2(MAX_STAMPS + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK     = 2'd3;

    localparam logic        RST_ENABLE    = 1'b1;
    localparam logic [15:0] RST_WINDOW    = 16'd10;
    localparam logic [6:0]  RST_THRESHOLD = 7'd5;
    localparam logic [15:0] RST_BLOCK     = 16'd60;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SRC_W-1:0]     t_src;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    // Channel payloads.
    typedef struct packed {
        logic [3:0]  source_id;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic        drop;
        logic        protection_entered;
        logic [31:0] blocked_total;
        logic [31:0] flood_attempts;
    } t_out;

    // Per-source record kept in the source table.
    typedef struct packed {
        logic  active;
        t_time blk_end;
        t_cnt  count;
        t_slot head;
    } t_src_rec;

    // Request to the stamp ring sweep engine and its response.
    typedef struct packed {
        t_src  src;
        t_slot start;
        t_cnt  scan;
        t_time cutoff;
        t_time now;
    } t_sweep_req;

    typedef struct packed {
        logic  done;
        t_cnt  kept;
        t_slot head;
    } t_sweep_rsp;

    function automatic t_slot slot_inc(input t_slot s);
        t_slot r;
        if (s == SLOT_W'(MAX_STAMPS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // Slot of the oldest entry: (head + MAX_STAMPS - cnt) mod MAX_STAMPS.
    function automatic t_slot oldest_slot(input t_slot head, input t_cnt cnt);
        logic [SLOT_W:0] sum;
        logic [SLOT_W:0] r;
        sum = (SLOT_W+1)'(head) + (SLOT_W+1)'(MAX_STAMPS) - (SLOT_W+1)'(cnt);
        if (sum >= (SLOT_W+1)'(MAX_STAMPS)) begin
            r = sum - (SLOT_W+1)'(MAX_STAMPS);
        end else begin
            r = sum;
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wrl_src_tbl.sv =====
// Per-source record table: block flag, block end, log count and ring head.
// Synchronous memory: read data is registered and appears in the cycle after i_rd_en; depends on wrl_pkg.
`default_nettype none

module wrl_src_tbl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire wrl_pkg::t_src     i_rd_idx,
    output wrl_pkg::t_src_rec      o_rd_rec,
    input  wire logic              i_wr_en,
    input  wire wrl_pkg::t_src     i_wr_idx,
    input  wire wrl_pkg::t_src_rec i_wr_rec
);
    import wrl_pkg::*;

    t_src_rec r_mem [NUM_SOURCES];
    logic     r_vld [NUM_SOURCES];
    t_src_rec r_rd_rec;
    logic     r_rd_vld;

    // A record never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_rec;
        end
        if (i_rd_en) begin
            r_rd_rec <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_rec = r_rd_vld ? r_rd_rec : '0;

endmodule

`default_nettype wire

// ===== rtl/wrl_sweep.sv =====
// Timestamp ring memory and the engine that expires old stamps and logs the new one.
// One read and one write per cycle on a single memory; depends on wrl_pkg.
`default_nettype none

module wrl_sweep (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire wrl_pkg::t_sweep_req i_req,
    output wrl_pkg::t_sweep_rsp      o_rsp
);
    import wrl_pkg::*;

    localparam int ADDR_W = SRC_W + SLOT_W;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SCAN,
        E_LOG
    } t_estate;

    t_estate    r_state;
    t_sweep_req r_req;
    t_slot      r_rd_slot;
    t_slot      r_wr_slot;
    t_cnt       r_rd_left;
    t_cnt       r_kept;
    logic       r_pend;
    t_time      r_rd_data;

    t_time r_ring [2**ADDR_W];

    logic        rd_en;
    logic        keep;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_time       wr_data;

    assign rd_en = (r_state == E_SCAN) && (r_rd_left != '0);
    // r_pend marks that r_rd_data holds a stamp read in the previous cycle.
    assign keep  = (r_state == E_SCAN) && r_pend && (r_rd_data >= r_req.cutoff);

    always_comb begin
        wr_en   = keep || (r_state == E_LOG);
        wr_addr = {r_req.src, r_wr_slot};
        wr_data = (r_state == E_LOG) ? r_req.now : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[{r_req.src, r_rd_slot}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_pend    <= 1'b0;
            r_rd_left <= '0;
            r_kept    <= '0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    r_pend <= 1'b0;
                    if (i_start) begin
                        r_req     <= i_req;
                        r_rd_slot <= i_req.start;
                        r_wr_slot <= i_req.start;
                        r_rd_left <= i_req.scan;
                        r_kept    <= '0;
                        r_state   <= E_SCAN;
                    end
                end
                E_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_rd_slot <= slot_inc(r_rd_slot);
                        r_rd_left <= r_rd_left - 1'b1;
                    end
                    if (keep) begin
                        r_wr_slot <= slot_inc(r_wr_slot);
                        r_kept    <= r_kept + 1'b1;
                    end
                    // Any stamp still in flight is consumed in this cycle.
                    if (r_rd_left == '0) begin
                        r_state <= E_LOG;
                    end
                end
                E_LOG: begin
                    r_pend  <= 1'b0;
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = (r_state == E_LOG);
        o_rsp.kept = r_kept;
        o_rsp.head = slot_inc(r_wr_slot);
    end

endmodule

`default_nettype wire

// ===== rtl/windowed_event_rate_limiter.sv =====
// Top level of the windowed event rate limiter: request handshake, sequencer,
// counters and configuration. Depends on wrl_pkg, wrl_src_tbl and wrl_sweep.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall   i_in_data  (t_in)
//   out      output     o_out_valid/i_out_stall o_out_data (t_out)
//   cfg      input      i_cfg_we                i_cfg_idx, i_cfg_data
//
// A request's sweep reads n stamps, n being the source's logged stamp count when
// expiry runs (0 otherwise), so at most MAX_STAMPS, one stamp per cycle on the
// single read port of the stamp ring.
// A blocked source skips the sweep, and a disabled limiter skips the lookup too.
// Reset is synchronous and clears the source table flags and both counters.
// A stalled result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module windowed_event_rate_limiter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire wrl_pkg::t_in                 i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output wrl_pkg::t_out                     o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [wrl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wrl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_RESULT
    } t_state;

    t_state      r_state;
    t_src        r_src;
    t_time       r_now;
    t_cnt        r_cnt;
    logic        r_expire;
    logic        r_drop;
    logic        r_entered;
    logic [31:0] r_dropped_cnt;
    logic [31:0] r_attempt_cnt;
    logic        r_enable;
    logic [15:0] r_window;
    logic [6:0]  r_thresh;
    logic [15:0] r_block;
    logic        r_out_valid;
    t_out        r_out_data;

    logic       accept;
    logic       src_ok;
    logic       tbl_rd_en;
    t_src_rec   tbl_rd_rec;
    logic       tbl_wr_en;
    t_src_rec   tbl_wr_rec;
    logic       blocked;
    logic       expire;
    logic       sweep_start;
    t_sweep_req sweep_req;
    t_sweep_rsp sweep_rsp;
    t_cnt       base_cnt;
    t_cnt       new_cnt;
    logic       hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign src_ok      = (32'(i_in_data.source_id) < NUM_SOURCES);
    assign tbl_rd_en   = accept && r_enable && src_ok;

    wrl_src_tbl u_src_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (tbl_rd_en),
        .i_rd_idx (SRC_W'(i_in_data.source_id)),
        .o_rd_rec (tbl_rd_rec),
        .i_wr_en  (tbl_wr_en),
        .i_wr_idx (r_src),
        .i_wr_rec (tbl_wr_rec)
    );

    // Lookup stage: decide between dropping and running the expiry sweep.
    always_comb begin
        blocked = tbl_rd_rec.active && (r_now < tbl_rd_rec.blk_end);
        expire  = (r_now >= TIME_BITS'(r_window)) && (tbl_rd_rec.count != '0);
        sweep_start      = (r_state == S_LOOK) && !blocked;
        sweep_req.src    = r_src;
        sweep_req.start  = expire ? oldest_slot(tbl_rd_rec.head, tbl_rd_rec.count)
                                  : tbl_rd_rec.head;
        sweep_req.scan   = expire ? tbl_rd_rec.count : '0;
        sweep_req.cutoff = r_now - TIME_BITS'(r_window);
        sweep_req.now    = r_now;
    end

    wrl_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sweep_start),
        .i_req   (sweep_req),
        .o_rsp   (sweep_rsp)
    );

    // Update stage: new count, threshold check and record write-back.
    always_comb begin
        base_cnt = r_expire ? sweep_rsp.kept : r_cnt;
        if (32'(base_cnt) < MAX_STAMPS) begin
            new_cnt = base_cnt + 1'b1;
        end else begin
            new_cnt = base_cnt;
        end
        hit = (32'(new_cnt) >= 32'(r_thresh));
        tbl_wr_en          = (r_state == S_SWEEP) && sweep_rsp.done;
        tbl_wr_rec.active  = hit;
        tbl_wr_rec.blk_end = r_now + TIME_BITS'(r_block);
        tbl_wr_rec.count   = new_cnt;
        tbl_wr_rec.head    = sweep_rsp.head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_dropped_cnt <= '0;
            r_attempt_cnt <= '0;
            r_enable      <= RST_ENABLE;
            r_window      <= RST_WINDOW;
            r_thresh      <= RST_THRESHOLD;
            r_block       <= RST_BLOCK;
            r_out_valid   <= 1'b0;
            r_drop        <= 1'b0;
            r_entered     <= 1'b0;
            r_expire      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:    r_enable <= i_cfg_data[0];
                    CFG_WINDOW:    r_window <= i_cfg_data[15:0];
                    CFG_THRESHOLD: r_thresh <= i_cfg_data[6:0];
                    CFG_BLOCK:     r_block  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            // In S_RESULT the output register is reloaded below instead.
            if (r_out_valid && !i_out_stall && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_src     <= SRC_W'(i_in_data.source_id);
                        r_now     <= TIME_BITS'(i_in_data.now_seconds);
                        r_drop    <= 1'b0;
                        r_entered <= 1'b0;
                        r_state   <= tbl_rd_en ? S_LOOK : S_RESULT;
                    end
                end
                S_LOOK: begin
                    if (blocked) begin
                        r_drop        <= 1'b1;
                        r_dropped_cnt <= r_dropped_cnt + 1'b1;
                        r_state       <= S_RESULT;
                    end else begin
                        r_cnt    <= tbl_rd_rec.count;
                        r_expire <= expire;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (sweep_rsp.done) begin
                        r_drop    <= hit;
                        r_entered <= hit;
                        if (hit) begin
                            r_dropped_cnt <= r_dropped_cnt + 1'b1;
                            r_attempt_cnt <= r_attempt_cnt + 1'b1;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid                   <= 1'b1;
                        r_out_data.drop               <= r_drop;
                        r_out_data.protection_entered <= r_entered;
                        r_out_data.blocked_total      <= r_dropped_cnt;
                        r_out_data.flood_attempts     <= r_attempt_cnt;
                        r_state                       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A new block always drops the request that started it.
    a_entered_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data.protection_entered || r_out_data.drop))
        else $error("protection_entered without drop");

    // The sweep engine only finishes while the sequencer waits for it.
    a_sweep_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_rsp.done |-> (r_state == S_SWEEP))
        else $error("sweep finished outside S_SWEEP");

    // Every block started is also counted as a dropped request.
    a_counters_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_attempt_cnt) |-> !$stable(r_dropped_cnt))
        else $error("flood counter moved without the drop counter");

endmodule

`default_nettype wire
